### design/pprj_pkg.sv
package pprj_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SH_UP = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
   localparam int SH_DN = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
   localparam logic signed [63:0] HALF_DN = (FRAC_BITS < 14) ? 64'sd1 <<< (SH_DN - 1) : 64'sd0;

   localparam int NUM_REGS = 8;
   localparam int IDX_W = 3;

   localparam logic [IDX_W-1:0] REG_ROT_I0 = 3'd0;
   localparam logic [IDX_W-1:0] REG_ROT_I1 = 3'd1;
   localparam logic [IDX_W-1:0] REG_ROT_I2 = 3'd2;
   localparam logic [IDX_W-1:0] REG_ROT_J0 = 3'd3;
   localparam logic [IDX_W-1:0] REG_ROT_J1 = 3'd4;
   localparam logic [IDX_W-1:0] REG_ROT_J2 = 3'd5;
   localparam logic [IDX_W-1:0] REG_DT_XY  = 3'd6;
   localparam logic [IDX_W-1:0] REG_DT_Z   = 3'd7;

   localparam logic [47:0] ROW0_RST = 48'd16384;
   localparam logic [47:0] ROW1_RST = 48'd1073741824;
   localparam logic [47:0] ROW2_RST = 48'd70368744177664;

   localparam int WN_W = 20;
   localparam int WP_W = 36;
   localparam int V_W  = 38;
   localparam int AN_W = 24;
   localparam int AV_W = 42;
   localparam int JS_W = 61;

   localparam int REQ_DATA_W = 240;
   localparam int RSP_DATA_W = 224;

   typedef struct packed {
      logic [2:0][47:0] rot_i;
      logic [2:0][47:0] rot_j;
      logic [63:0]      dt_xy;
      logic [31:0]      dt_z;
   } cfg_type;

   typedef struct packed {
      logic               batch_end;
      logic [REQ_DATA_W-1:0] data;
   } item_type;

   // floor((x + 2^13) / 2^14)
   function automatic logic signed [63:0] rnd14(input logic signed [63:0] x);
      return (x + 64'sd8192) >>> 14;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      logic [31:0] r;
      if (x > 64'sd2147483647) r = 32'h7fff_ffff;
      else if (x < -64'sd2147483648) r = 32'h8000_0000;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [63:0] q14_to_frac(input logic signed [63:0] x);
      logic signed [63:0] r;
      if (FRAC_BITS >= 14) r = x <<< SH_UP;
      else r = (x + HALF_DN) >>> SH_DN;
      return r;
   endfunction

endpackage

### design/pprj_front.sv
module pprj_front import pprj_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  item_type        in_item,
   output logic            out_valid,
   input  logic            out_pop,
   output item_type        out_item
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_item;
   end

endmodule

### design/pprj_back.sv
module pprj_back import pprj_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   output logic                  in_pop,
   input  item_type              in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [RSP_DATA_W-1:0] out_data,
   output logic                  out_pose,
   output logic                  out_batch_end
);

   logic signed [15:0] ri [3][3];
   logic signed [15:0] rj [3][3];
   logic signed [31:0] d  [3];
   logic signed [31:0] pi0 [3];
   logic signed [15:0] ni0 [3];
   logic signed [31:0] pj0 [3];

   // stage 1
   logic               v1_ff;
   logic signed [WN_W-1:0] wn1_ff [3];
   logic signed [WP_W-1:0] wpi1_ff [3];
   logic signed [WP_W-1:0] wpj1_ff [3];
   logic signed [31:0] pi1_ff [3];
   logic signed [15:0] ni1_ff [3];
   logic signed [31:0] pj1_ff [3];
   logic               be1_ff;
   // stage 2
   logic               v2_ff;
   logic signed [WN_W-1:0] wn2_ff [3];
   logic signed [V_W-1:0]  v2v_ff [3];
   logic signed [AN_W-1:0] an2_ff [3];
   logic signed [AN_W-1:0] bn2_ff [3];
   logic signed [31:0] pi2_ff [3];
   logic signed [15:0] ni2_ff [3];
   logic signed [31:0] pj2_ff [3];
   logic               be2_ff;
   // stage 3
   logic               v3_ff;
   logic signed [JS_W-1:0] res3_ff;
   logic signed [AV_W-1:0] av3_ff [3];
   logic signed [AN_W-1:0] an3_ff [3];
   logic signed [AN_W-1:0] bn3_ff [3];
   logic signed [31:0] pi3_ff [3];
   logic signed [15:0] ni3_ff [3];
   logic signed [31:0] pj3_ff [3];
   logic               be3_ff;
   // stage 4
   logic               v4_ff;
   logic signed [JS_W-1:0] res4_ff;
   logic signed [JS_W-1:0] ji4_ff [3];
   logic signed [JS_W-1:0] jj4_ff [3];
   logic signed [AN_W-1:0] an4_ff [3];
   logic signed [AN_W-1:0] bn4_ff [3];
   logic               be4_ff;
   // output
   logic               ov_ff, ov_in;
   logic               phase_ff, phase_in;
   logic [RSP_DATA_W-1:0] row_i_ff, row_j_ff, row_i_in, row_j_in;
   logic               obe_ff;

   logic en, load, take;

   assign take = ov_ff && out_ready;
   assign en   = !ov_ff || (take && phase_ff);
   assign load = en && v4_ff;
   assign in_pop = en && in_valid;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            ri[r][c] = cfg.rot_i[r][16*c +: 16];
            rj[r][c] = cfg.rot_j[r][16*c +: 16];
         end
      end
      d[0] = cfg.dt_xy[31:0];
      d[1] = cfg.dt_xy[63:32];
      d[2] = cfg.dt_z;
      for (int k = 0; k < 3; k++) begin
         pi0[k] = in_item.data[32*k +: 32];
         ni0[k] = in_item.data[96 + 16*k +: 16];
         pj0[k] = in_item.data[144 + 32*k +: 32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            wn1_ff[r] <= WN_W'(rnd14(64'(
               34'(ri[r][0]) * 34'(ni0[0]) + 34'(ri[r][1]) * 34'(ni0[1])
               + 34'(ri[r][2]) * 34'(ni0[2]))));
            wpi1_ff[r] <= WP_W'(rnd14(64'(
               50'(ri[r][0]) * 50'(pi0[0]) + 50'(ri[r][1]) * 50'(pi0[1])
               + 50'(ri[r][2]) * 50'(pi0[2]))));
            wpj1_ff[r] <= WP_W'(rnd14(64'(
               50'(rj[r][0]) * 50'(pj0[0]) + 50'(rj[r][1]) * 50'(pj0[1])
               + 50'(rj[r][2]) * 50'(pj0[2]))));
            pi1_ff[r] <= pi0[r];
            ni1_ff[r] <= ni0[r];
            pj1_ff[r] <= pj0[r];

            v2v_ff[r] <= V_W'(wpj1_ff[r]) - V_W'(wpi1_ff[r]) + V_W'(d[r]);
            // transposed products
            an2_ff[r] <= AN_W'(rnd14(64'(
               38'(ri[0][r]) * 38'(wn1_ff[0]) + 38'(ri[1][r]) * 38'(wn1_ff[1])
               + 38'(ri[2][r]) * 38'(wn1_ff[2]))));
            bn2_ff[r] <= AN_W'(rnd14(64'(
               38'(rj[0][r]) * 38'(wn1_ff[0]) + 38'(rj[1][r]) * 38'(wn1_ff[1])
               + 38'(rj[2][r]) * 38'(wn1_ff[2]))));
            wn2_ff[r] <= wn1_ff[r];
            pi2_ff[r] <= pi1_ff[r];
            ni2_ff[r] <= ni1_ff[r];
            pj2_ff[r] <= pj1_ff[r];

            av3_ff[r] <= AV_W'(rnd14(64'(
               58'(ri[0][r]) * 58'(v2v_ff[0]) + 58'(ri[1][r]) * 58'(v2v_ff[1])
               + 58'(ri[2][r]) * 58'(v2v_ff[2]))));
            an3_ff[r] <= an2_ff[r];
            bn3_ff[r] <= bn2_ff[r];
            pi3_ff[r] <= pi2_ff[r];
            ni3_ff[r] <= ni2_ff[r];
            pj3_ff[r] <= pj2_ff[r];

            an4_ff[r] <= an3_ff[r];
            bn4_ff[r] <= bn3_ff[r];
         end
         be1_ff <= in_item.batch_end;
         be2_ff <= be1_ff;
         be3_ff <= be2_ff;
         be4_ff <= be3_ff;

         res3_ff <= JS_W'(wn2_ff[0]) * JS_W'(v2v_ff[0]) + JS_W'(wn2_ff[1]) * JS_W'(v2v_ff[1])
                  + JS_W'(wn2_ff[2]) * JS_W'(v2v_ff[2]);
         res4_ff <= res3_ff;

         ji4_ff[0] <= JS_W'(an3_ff[1]) * JS_W'(pi3_ff[2]) - JS_W'(an3_ff[2]) * JS_W'(pi3_ff[1])
                    - JS_W'(av3_ff[1]) * JS_W'(ni3_ff[2]) + JS_W'(av3_ff[2]) * JS_W'(ni3_ff[1]);
         ji4_ff[1] <= JS_W'(an3_ff[2]) * JS_W'(pi3_ff[0]) - JS_W'(an3_ff[0]) * JS_W'(pi3_ff[2])
                    - JS_W'(av3_ff[2]) * JS_W'(ni3_ff[0]) + JS_W'(av3_ff[0]) * JS_W'(ni3_ff[2]);
         ji4_ff[2] <= JS_W'(an3_ff[0]) * JS_W'(pi3_ff[1]) - JS_W'(an3_ff[1]) * JS_W'(pi3_ff[0])
                    - JS_W'(av3_ff[0]) * JS_W'(ni3_ff[1]) + JS_W'(av3_ff[1]) * JS_W'(ni3_ff[0]);
         jj4_ff[0] <= JS_W'(bn3_ff[2]) * JS_W'(pj3_ff[1]) - JS_W'(bn3_ff[1]) * JS_W'(pj3_ff[2]);
         jj4_ff[1] <= JS_W'(bn3_ff[0]) * JS_W'(pj3_ff[2]) - JS_W'(bn3_ff[2]) * JS_W'(pj3_ff[0]);
         jj4_ff[2] <= JS_W'(bn3_ff[1]) * JS_W'(pj3_ff[0]) - JS_W'(bn3_ff[0]) * JS_W'(pj3_ff[1]);
      end
   end

   always_comb begin
      logic [31:0] res_q;
      res_q = sat32(rnd14(64'(res4_ff)));
      row_i_in[31:0] = res_q;
      row_j_in[31:0] = res_q;
      for (int k = 0; k < 3; k++) begin
         row_i_in[32 + 32*k +: 32] = sat32(rnd14(64'(ji4_ff[k])));
         row_j_in[32 + 32*k +: 32] = sat32(rnd14(64'(jj4_ff[k])));
         row_i_in[128 + 32*k +: 32] = sat32(-q14_to_frac(64'(an4_ff[k])));
         row_j_in[128 + 32*k +: 32] = sat32(q14_to_frac(64'(bn4_ff[k])));
      end
   end

   always_comb begin
      ov_in    = ov_ff;
      phase_in = phase_ff;
      if (take) begin
         if (phase_ff) ov_in = 1'b0;
         else phase_in = 1'b1;
      end
      if (load) begin
         ov_in    = 1'b1;
         phase_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff    <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         ov_ff    <= ov_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_i_ff <= row_i_in;
         row_j_ff <= row_j_in;
         obe_ff   <= be4_ff;
      end
   end

   assign out_valid     = ov_ff;
   assign out_data      = phase_ff ? row_j_ff : row_i_ff;
   assign out_pose      = phase_ff;
   assign out_batch_end = obe_ff;

endmodule

### design/point_to_plane_residual_jacobian_unit.sv
// Point-to-plane residual and Jacobian unit.
// req_* carries one correspondence per word: point and normal in frame i and
// point in frame j; req_tlast marks the last correspondence of a batch.
// rsp_* returns two words per correspondence: the Jacobian row for pose i
// (tuser bit 0 low) then the row for pose j (bit 0 high, tlast high); both
// carry the residual, and tuser bit 1 repeats the batch end flag.
// csr_* writes the rotation rows and translation difference; write only
// while the unit is empty.
// A req word accepted into an empty unit passes the input queue, four
// arithmetic stages and the output register before rsp_tvalid rises.
// Results leave as two words per item on the single result port; the stages
// advance only while the output register is empty or its last word is taken.
// Reset (synchronous) empties the queue and pipeline and loads identity
// rotations with zero translation. When rsp_tready is low and a result waits,
// the pipeline holds, the two-entry input queue fills and then req_tready drops.
module point_to_plane_residual_jacobian_unit import pprj_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // point_i_x, point_i_y, point_i_z, normal_i_x, normal_i_y, normal_i_z,
   // point_j_x, point_j_y, point_j_z
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // residual, jac_rot_x, jac_rot_y, jac_rot_z, jac_trans_x, jac_trans_y, jac_trans_z
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // pose_select, batch_end_out
   output logic [1:0]            rsp_tuser,
   input  logic                  csr_we,
   input  logic [IDX_W-1:0]      csr_index,
   input  logic [63:0]           csr_wdata
);

   cfg_type  cfg_ff;
   item_type req_item, q_item;
   logic     q_valid, q_pop, pose, be;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_i <= {ROW2_RST, ROW1_RST, ROW0_RST};
         cfg_ff.rot_j <= {ROW2_RST, ROW1_RST, ROW0_RST};
         cfg_ff.dt_xy <= 64'd0;
         cfg_ff.dt_z  <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ROT_I0: cfg_ff.rot_i[0] <= csr_wdata[47:0];
            REG_ROT_I1: cfg_ff.rot_i[1] <= csr_wdata[47:0];
            REG_ROT_I2: cfg_ff.rot_i[2] <= csr_wdata[47:0];
            REG_ROT_J0: cfg_ff.rot_j[0] <= csr_wdata[47:0];
            REG_ROT_J1: cfg_ff.rot_j[1] <= csr_wdata[47:0];
            REG_ROT_J2: cfg_ff.rot_j[2] <= csr_wdata[47:0];
            REG_DT_XY:  cfg_ff.dt_xy    <= csr_wdata;
            REG_DT_Z:   cfg_ff.dt_z     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign req_item.data      = req_tdata;
   assign req_item.batch_end = req_tlast;

   pprj_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_item  (q_item)
   );

   pprj_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (q_valid),
      .in_pop        (q_pop),
      .in_item       (q_item),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_data      (rsp_tdata),
      .out_pose      (pose),
      .out_batch_end (be)
   );

   assign rsp_tlast = pose;
   assign rsp_tuser = {be, pose};

endmodule
